// ----- hw/rtl/qpe_pkg.sv -----
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared widths, register indexes and payload types of the quadrature
// period encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam int CFG_W          = 24;  // widest configuration register
  localparam int CFG_IDX_W      = 1;
  localparam int PERIOD_W       = 24;
  localparam int POS_W          = 32;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 64;

  localparam int TIMER_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'd1;

  localparam logic [CFG_W-1:0] START_MIN_RST = 24'd10000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 24'd100000;

  typedef struct packed {
    logic [CFG_W-1:0] start_min;
    logic [CFG_W-1:0] timeout;
  } qpe_cfg_t;

  // packed so that period sits in the lowest bits
  typedef struct packed {
    logic                edge_seen;
    logic                running;
    logic                reversed;
    logic [POS_W-1:0]    position;
    logic [PERIOD_W-1:0] period;
  } qpe_result_t;

  localparam int RES_W = $bits(qpe_result_t);

endpackage

// ----- hw/rtl/qpe_core.sv -----
// ----------------------------------------------------------------------------
// qpe_core
// Edge qualification, period and idle timers and position count; state
// advances by one tick for every accepted transaction.
// ----------------------------------------------------------------------------
module qpe_core import qpe_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        chan_a,
  input  logic        chan_b,
  input  qpe_cfg_t    cfg,
  output qpe_result_t res
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic                  a_last_r,     a_last_nxt;
  logic                  level_prev_r, level_prev_nxt;
  logic                  meas_valid_r, meas_valid_nxt;
  logic                  run_flag_r,   run_flag_nxt;
  logic                  dir_flag_r,   dir_flag_nxt;
  logic [TIMER_BITS-1:0] period_r,     period_nxt;
  logic [TIMER_BITS-1:0] since_r,      since_nxt;
  logic [TIMER_BITS-1:0] idle_r,       idle_nxt;
  logic [COUNT_BITS-1:0] count_r,      count_nxt;

  logic [TIMER_BITS-1:0] since_inc;
  logic [TIMER_BITS-1:0] idle_inc;
  logic                  a_chg;
  logic                  rise;
  logic                  fall;
  logic                  meas_edge;
  logic                  start_ok;
  logic                  timeout_hit;
  logic [CMP_W-1:0]      period_ext;

  always_comb begin
    since_inc   = (since_r == '1) ? since_r : since_r + 1'b1;
    idle_inc    = (idle_r  == '1) ? idle_r  : idle_r  + 1'b1;
    a_chg       = chan_a ^ a_last_r;
    rise        = a_chg &  chan_a & ~level_prev_r;
    fall        = a_chg & ~chan_a &  level_prev_r;
    meas_edge   = rise & meas_valid_r;
    start_ok    = run_flag_r | (CMP_W'(since_inc) > CMP_W'(cfg.start_min));

    a_last_nxt     = chan_a;
    idle_nxt       = a_chg ? '0 : idle_inc;
    since_nxt      = rise  ? '0 : since_inc;
    level_prev_nxt = level_prev_r;
    meas_valid_nxt = meas_valid_r;
    run_flag_nxt   = run_flag_r;
    period_nxt     = period_r;
    dir_flag_nxt   = dir_flag_r;
    count_nxt      = count_r;

    if (meas_edge) begin
      if (start_ok) begin
        run_flag_nxt = 1'b1;
        period_nxt   = since_inc;
      end else begin
        period_nxt   = '0;
      end
      dir_flag_nxt = chan_b;
      // channel b low counts up, high counts down
      count_nxt    = chan_b ? count_r - 1'b1 : count_r + 1'b1;
    end

    if (rise) begin
      level_prev_nxt = 1'b1;
    end else if (fall) begin
      level_prev_nxt = 1'b0;
      meas_valid_nxt = 1'b1;
    end

    timeout_hit = CMP_W'(idle_nxt) >= CMP_W'(cfg.timeout);
    if (timeout_hit) begin
      period_nxt     = '0;
      level_prev_nxt = 1'b0;
      run_flag_nxt   = 1'b0;
      meas_valid_nxt = 1'b0;
    end

    period_ext    = CMP_W'(period_nxt);
    res.period    = period_ext[PERIOD_W-1:0];
    res.position  = POS_W'($signed(count_nxt));
    res.reversed  = dir_flag_nxt;
    res.running   = run_flag_nxt;
    res.edge_seen = meas_edge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_last_r     <= 1'b0;
      level_prev_r <= 1'b0;
      meas_valid_r <= 1'b0;
      run_flag_r   <= 1'b0;
      dir_flag_r   <= 1'b0;
      period_r     <= '0;
      since_r      <= '0;
      idle_r       <= '0;
      count_r      <= '0;
    end else if (step) begin
      a_last_r     <= a_last_nxt;
      level_prev_r <= level_prev_nxt;
      meas_valid_r <= meas_valid_nxt;
      run_flag_r   <= run_flag_nxt;
      dir_flag_r   <= dir_flag_nxt;
      period_r     <= period_nxt;
      since_r      <= since_nxt;
      idle_r       <= idle_nxt;
      count_r      <= count_nxt;
    end
  end

  // a nonzero period only exists while running
  a_period_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r != '0) |-> run_flag_r)
    else $error("period held while not running");

  // timeout leaves measurement fully reset
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && timeout_hit) |=> (!run_flag_r && !meas_valid_r && !level_prev_r))
    else $error("timeout did not clear measurement state");

  // a measured edge always moves the count
  a_edge_moves_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step && meas_edge) |=> (count_r != $past(count_r)))
    else $error("measured edge left count unchanged");

  // no tick, no state change
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(count_r) && $stable(since_r) && $stable(idle_r)))
    else $error("state moved without a transaction");

endmodule

// ----- hw/rtl/quadrature_period_encoder.sv -----
// ----------------------------------------------------------------------------
// quadrature_period_encoder
// Quadrature encoder period measurement: one transaction per sampled tick,
// one result per tick with period, position, direction and run status.
//
//   channel | direction | fields
//   --------+-----------+----------------------------------------------------
//   in_     | slave     | chan_a, chan_b
//   out_    | master    | period, position, reversed, running, edge_seen
//   cfg_    | write     | start_period_min (0), timeout_ticks (1)
//
// One tick per cycle while the output is not held: the tick is processed in the cycle it is accepted and
// its result is registered in the output stage.
// A held output blocks the input: a new tick is taken only when the output
// register is empty or being drained in the same cycle.
// out_tvalid is raised in the cycle after input acceptance.
// Synchronous active-low reset clears all state but the output data register;
// configuration returns to start_period_min 10000 and timeout_ticks 100000.
// ----------------------------------------------------------------------------
module quadrature_period_encoder import qpe_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // chan_a, chan_b
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // period[23:0], position[55:24], reversed, running, edge_seen
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  qpe_cfg_t    cfg_r;
  qpe_result_t res;
  qpe_result_t res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min <= START_MIN_RST;
      cfg_r.timeout   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_MIN: cfg_r.start_min <= cfg_wdata;
        REG_TIMEOUT:   cfg_r.timeout   <= cfg_wdata;
      endcase
    end
  end

  assign in_tready = ~out_valid_r | out_tready;
  assign step      = in_tvalid & in_tready;

  qpe_core #(
    .TIMER_BITS(TIMER_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .chan_a(in_tdata[0]),
    .chan_b(in_tdata[1]),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_r};

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrature period encoder. Encoder waveforms,
// noise and glitches are streamed in one tick per transaction. A scoreboard
// predicts every result tick and checks the outputs field by field. The
// bench runs under several start and timeout settings, with random sender
// gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import qpe_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int CYCLE_MAX  = 400000;
  localparam int RAND_ITEMS = 800;

  class qpe_scoreboard;
    logic [CFG_W-1:0]    start_min;
    logic [CFG_W-1:0]    timeout;
    bit                  a_last;
    bit                  lvl_high;
    bit                  armed;
    bit                  run;
    bit                  dir;
    bit [PERIOD_W-1:0]   period;
    bit [PERIOD_W-1:0]   since_rise;
    bit [PERIOD_W-1:0]   idle;
    bit [POS_W-1:0]      count;
    qpe_result_t         expected_q[$];
    int                  errors;

    function new();
      start_min  = START_MIN_RST;
      timeout    = TIMEOUT_RST;
      a_last     = 0;
      lvl_high   = 0;
      armed      = 0;
      run        = 0;
      dir        = 0;
      period     = '0;
      since_rise = '0;
      idle       = '0;
      count      = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_START_MIN) start_min = val;
      else if (idx == REG_TIMEOUT) timeout = val;
    endfunction

    // one accepted tick in, one expected result out
    function void note_tick(bit a, bit b);
      qpe_result_t r;
      bit edge_hit;
      edge_hit = 0;
      if (since_rise != '1) since_rise++;
      if (idle != '1) idle++;
      if (a != a_last) begin
        idle = '0;
        if (a) begin
          if (!lvl_high) begin
            if (armed) begin
              edge_hit = 1;
              if (run || since_rise > start_min) begin
                run    = 1;
                period = since_rise;
              end else begin
                period = '0;
              end
              dir = b;
              if (!b) count = count + 1;
              else count = count - 1;
            end
            since_rise = '0;
            lvl_high   = 1;
          end
        end else if (lvl_high) begin
          lvl_high = 0;
          armed    = 1;
        end
      end
      a_last = a;
      if (idle >= timeout) begin
        period   = '0;
        lvl_high = 0;
        run      = 0;
        armed    = 0;
      end
      r.period    = period;
      r.position  = count;
      r.reversed  = dir;
      r.running   = run;
      r.edge_seen = edge_hit;
      expected_q.push_back(r);
    endfunction

    function void check_result(qpe_result_t got);
      qpe_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result tick: %h", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.period !== exp_r.period || got.position !== exp_r.position ||
          got.reversed !== exp_r.reversed || got.running !== exp_r.running ||
          got.edge_seen !== exp_r.edge_seen) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at %0t: period %0d/%0d pos %0d/%0d rev %b/%b run %b/%b edge %b/%b",
                   $realtime, exp_r.period, got.period, $signed(exp_r.position),
                   $signed(got.position), exp_r.reversed, got.reversed,
                   exp_r.running, got.running, exp_r.edge_seen, got.edge_seen);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // chan_a, chan_b
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // period[23:0], position[55:24], reversed, running, edge_seen
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  qpe_scoreboard sb = new();

  int cycles       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int burst_left   = 0;
  int hold_left    = 0;
  bit hold_done    = 0;
  int rx_tick      = 0;

  quadrature_period_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("[quadrature_period_encoder] ERROR");
      $finish;
    end
  end

  // result side: own stall pattern plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(qpe_result_t'(out_tdata[RES_W-1:0]));
      results_seen++;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1;
      hold_left = 400;
      out_tready <= 1'b0;
    end else begin
      case ((rx_tick >> 6) % 5)
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (rx_tick % 3 == 0);
        3:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= 1'b1;
      endcase
    end
    rx_tick++;
  end

  task automatic send_tick(bit a, bit b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-2){1'b0}}, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(a, b);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] start_v, logic [CFG_W-1:0] timeout_v);
    drain();
    write_reg(REG_START_MIN, start_v);
    write_reg(REG_TIMEOUT, timeout_v);
  endtask

  // encoder periods: b sits at dir on the rising edge of a, then swaps mid-half
  task automatic quad_burst(int periods, int lo, int hi, bit dir);
    int hi_len;
    int lo_len;
    for (int p = 0; p < periods; p++) begin
      hi_len = $urandom_range(lo, hi);
      lo_len = $urandom_range(lo, hi);
      for (int i = 0; i < hi_len; i++) send_tick(1'b1, (i < (hi_len + 1) / 2) ? dir : !dir);
      for (int i = 0; i < lo_len; i++) send_tick(1'b0, (i < (lo_len + 1) / 2) ? !dir : dir);
    end
  endtask

  task automatic random_traffic(int n_items);
    int stop_at;
    int len;
    bit lvl;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        6: begin
          len = $urandom_range(3, 20);
          repeat (len) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        7: begin
          // hold a steady, for about the idle timeout when it is under 200, else for 40 ticks
          len = (sb.timeout < 200) ? sb.timeout + $urandom_range(0, 3) : 40;
          lvl = 1'($urandom_range(0, 1));
          repeat (len) send_tick(lvl, 1'($urandom_range(0, 1)));
        end
        8: begin
          // glitch: one-tick dropout of a while high
          lvl = 1'($urandom_range(0, 1));
          send_tick(1'b1, lvl);
          send_tick(1'b0, lvl);
          send_tick(1'b1, !lvl);
        end
        default: quad_burst($urandom_range(1, 6), 1, $urandom_range(1, 25),
                            1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first rise is not measured, short periods report zero
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);

    // any period starts the motor, a steady tick times out at once
    set_config('0, 24'd1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);

    // zero timeout clears measurement on every tick
    set_config('0, '0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);

    // largest threshold never starts the motor, largest timeout never fires
    set_config('1, '1);
    random_traffic(60);

    for (int ph = 0; ph < 4; ph++) begin
      set_config((ph == 0) ? '0 : CFG_W'($urandom_range(0, 30)),
                 CFG_W'($urandom_range(4, 150)));
      random_traffic(RAND_ITEMS / 5);
    end
    set_config(CFG_W'($urandom_range(0, 8)), '1);
    random_traffic(RAND_ITEMS / 5);

    drain();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[quadrature_period_encoder] OK");
    end else begin
      $display("[quadrature_period_encoder] ERROR");
    end
    $finish;
  end

endmodule
